// ===== rtl/core/ole_pkg.sv =====
// ----------------------------------------------------------------------------
// ole_pkg
// Shared types and constants for the ordered list engine: sizes, operation
// and status codes, and the command broadcast to the row of list cells.
// ----------------------------------------------------------------------------
package ole_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int LEN_W    = $clog2(CAPACITY + 1);
    localparam int VAL_W    = 32;
    localparam int OP_W     = 2;
    localparam int POS_W    = 7;
    localparam int STAT_W   = 2;
    localparam int OLEN_W   = 7;
    localparam int CMP_W    = (LEN_W > POS_W) ? LEN_W : POS_W;

    typedef enum logic [OP_W-1:0] {
        OP_INS_FRONT = 2'd0,
        OP_INS_BACK  = 2'd1,
        OP_DELETE    = 2'd2,
        OP_SEARCH    = 2'd3
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK      = 2'd0,
        STAT_FULL    = 2'd1,
        STAT_BAD_POS = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic             strobe;
        logic             ok;
        op_t              op;
        logic [VAL_W-1:0] key;
        logic [LEN_W-1:0] pos_idx;
        logic [LEN_W-1:0] length;
    } cell_cmd_t;

endpackage

// ===== rtl/core/ole_cell.sv =====
// ----------------------------------------------------------------------------
// ole_cell
// One list slot: holds a value and its valid bit, shifts with its neighbors
// on front insert and delete, and registers a key match on every command.
// ----------------------------------------------------------------------------
module ole_cell (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [ole_pkg::IDX_W-1:0]   index,
    input  ole_pkg::cell_cmd_t          cmd,
    input  logic [ole_pkg::VAL_W-1:0]   left_value,
    input  logic                        left_valid,
    input  logic [ole_pkg::VAL_W-1:0]   right_value,
    input  logic                        right_valid,
    output logic [ole_pkg::VAL_W-1:0]   value_out,
    output logic                        valid_out,
    output logic                        hit
);

    logic [ole_pkg::VAL_W-1:0] value_reg;
    logic [ole_pkg::VAL_W-1:0] value_next;
    logic                      valid_reg;
    logic                      valid_next;
    logic                      hit_reg;
    logic                      hit_next;
    logic [ole_pkg::LEN_W-1:0] index_ext;

    assign index_ext = ole_pkg::LEN_W'(index);

    always_comb
    begin
        value_next = value_reg;
        valid_next = valid_reg;
        hit_next   = hit_reg;
        if (cmd.strobe)
        begin
            hit_next = valid_reg && (value_reg == cmd.key);
            if (cmd.ok)
            begin
                unique case (cmd.op)
                    ole_pkg::OP_INS_FRONT:
                    begin
                        if (index == '0)
                        begin
                            value_next = cmd.key;
                            valid_next = 1'b1;
                        end
                        else
                        begin
                            value_next = left_value;
                            valid_next = left_valid;
                        end
                    end
                    ole_pkg::OP_INS_BACK:
                    begin
                        if (index_ext == cmd.length)
                        begin
                            value_next = cmd.key;
                            valid_next = 1'b1;
                        end
                    end
                    ole_pkg::OP_DELETE:
                    begin
                        if (index_ext >= cmd.pos_idx)
                        begin
                            value_next = right_value;
                            valid_next = right_valid;
                        end
                    end
                    ole_pkg::OP_SEARCH:
                    begin
                        value_next = value_reg;
                    end
                    default:
                    begin
                        value_next = value_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            hit_reg   <= hit_next;
        end
    end

    assign value_out = value_reg;
    assign valid_out = valid_reg;
    assign hit       = hit_reg;

endmodule

// ===== rtl/core/ordered_list_engine_core.sv =====
// ----------------------------------------------------------------------------
// ordered_list_engine_core
// Ordered list of signed values held in a row of shifting cells: insert at
// front or back, delete at a position, search for a value.
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_ready    operation, value, position
//   out      output     out_valid / out_ready  found, status, length
//
// Each transaction passes through three steps: accept, cell update with parallel
// match, then result resolve into the output register.
// One transaction is in flight at a time; the next is taken as soon as the
// result is registered, even while that result waits on out_ready.
// A stalled output holds the resolve step. Reset empties the list at once.
// ----------------------------------------------------------------------------
module ordered_list_engine_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [ole_pkg::OP_W-1:0]      operation,
    input  logic signed [ole_pkg::VAL_W-1:0] value,
    input  logic [ole_pkg::POS_W-1:0]     position,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          found,
    output logic [ole_pkg::STAT_W-1:0]    status,
    output logic [ole_pkg::OLEN_W-1:0]    length
);

    ole_pkg::state_t              state_reg;
    ole_pkg::state_t              state_next;
    ole_pkg::op_t                 op_reg;
    logic [ole_pkg::VAL_W-1:0]    key_reg;
    logic [ole_pkg::POS_W-1:0]    pos_reg;
    logic [ole_pkg::LEN_W-1:0]    length_reg;
    logic [ole_pkg::LEN_W-1:0]    length_next;
    ole_pkg::status_t             status_reg;
    ole_pkg::status_t             status_next;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic                         found_reg;
    logic                         found_next;
    logic [ole_pkg::STAT_W-1:0]   out_status_reg;
    logic [ole_pkg::STAT_W-1:0]   out_status_next;
    logic [ole_pkg::OLEN_W-1:0]   out_length_reg;
    logic [ole_pkg::OLEN_W-1:0]   out_length_next;
    logic                         in_fire;

    logic                         full;
    logic                         bad_pos;
    logic [ole_pkg::CMP_W-1:0]    pos_ext;
    logic [ole_pkg::CMP_W-1:0]    len_ext;
    logic                         op_ok;
    ole_pkg::cell_cmd_t           cmd;

    logic [ole_pkg::VAL_W-1:0]    cell_value [ole_pkg::CAPACITY];
    logic                         cell_valid [ole_pkg::CAPACITY];
    logic [ole_pkg::CAPACITY-1:0] cell_hit;

    assign in_ready = (state_reg == ole_pkg::ST_IDLE);
    assign in_fire  = in_valid && in_ready;

    assign full    = (length_reg == ole_pkg::LEN_W'(ole_pkg::CAPACITY));
    assign pos_ext = ole_pkg::CMP_W'(pos_reg);
    assign len_ext = ole_pkg::CMP_W'(length_reg);
    assign bad_pos = (pos_reg == '0) || (pos_ext > len_ext);

    always_comb
    begin
        unique case (op_reg)
            ole_pkg::OP_INS_FRONT,
            ole_pkg::OP_INS_BACK:
            begin
                op_ok = !full;
            end
            ole_pkg::OP_DELETE:
            begin
                op_ok = !bad_pos;
            end
            default:
            begin
                op_ok = 1'b0;
            end
        endcase
    end

    assign cmd.strobe  = (state_reg == ole_pkg::ST_EXEC);
    assign cmd.ok      = op_ok;
    assign cmd.op      = op_reg;
    assign cmd.key     = key_reg;
    assign cmd.pos_idx = ole_pkg::LEN_W'(pos_ext - ole_pkg::CMP_W'(1));
    assign cmd.length  = length_reg;

    for (genvar g = 0; g < ole_pkg::CAPACITY; g++)
    begin : g_cell
        logic [ole_pkg::VAL_W-1:0] lv;
        logic                      lval;
        logic [ole_pkg::VAL_W-1:0] rv;
        logic                      rval;

        if (g == 0)
        begin : g_first
            assign lv   = '0;
            assign lval = 1'b0;
        end
        else
        begin : g_mid_l
            assign lv   = cell_value[g-1];
            assign lval = cell_valid[g-1];
        end

        if (g == ole_pkg::CAPACITY - 1)
        begin : g_last
            assign rv   = '0;
            assign rval = 1'b0;
        end
        else
        begin : g_mid_r
            assign rv   = cell_value[g+1];
            assign rval = cell_valid[g+1];
        end

        ole_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .index       (ole_pkg::IDX_W'(g)),
            .cmd         (cmd),
            .left_value  (lv),
            .left_valid  (lval),
            .right_value (rv),
            .right_valid (rval),
            .value_out   (cell_value[g]),
            .valid_out   (cell_valid[g]),
            .hit         (cell_hit[g])
        );
    end

    always_comb
    begin
        state_next      = state_reg;
        length_next     = length_reg;
        status_next     = status_reg;
        out_valid_next  = out_valid_reg;
        found_next      = found_reg;
        out_status_next = out_status_reg;
        out_length_next = out_length_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ole_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = ole_pkg::ST_EXEC;
                end
            end
            ole_pkg::ST_EXEC:
            begin
                status_next = ole_pkg::STAT_OK;
                unique case (op_reg)
                    ole_pkg::OP_INS_FRONT,
                    ole_pkg::OP_INS_BACK:
                    begin
                        if (full)
                        begin
                            status_next = ole_pkg::STAT_FULL;
                        end
                        else
                        begin
                            length_next = length_reg + ole_pkg::LEN_W'(1);
                        end
                    end
                    ole_pkg::OP_DELETE:
                    begin
                        if (bad_pos)
                        begin
                            status_next = ole_pkg::STAT_BAD_POS;
                        end
                        else
                        begin
                            length_next = length_reg - ole_pkg::LEN_W'(1);
                        end
                    end
                    default:
                    begin
                        status_next = ole_pkg::STAT_OK;
                    end
                endcase
                state_next = ole_pkg::ST_DONE;
            end
            ole_pkg::ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    found_next      = (op_reg == ole_pkg::OP_SEARCH) && (|cell_hit);
                    out_status_next = status_reg;
                    out_length_next = ole_pkg::OLEN_W'(length_reg);
                    state_next      = ole_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ole_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            op_reg  <= ole_pkg::op_t'(operation);
            key_reg <= value;
            pos_reg <= position;
        end
        status_reg     <= status_next;
        found_reg      <= found_next;
        out_status_reg <= out_status_next;
        out_length_reg <= out_length_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ole_pkg::ST_IDLE;
            length_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            length_reg    <= length_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign found     = found_reg;
    assign status    = out_status_reg;
    assign length    = out_length_reg;

endmodule
